[hw/rtl/reed_solomon_parity_gf256_top_defines.svh]
// Assertion helpers for the Reed-Solomon parity generator.
`ifndef REED_SOLOMON_PARITY_GF256_TOP_DEFINES_SVH
`define REED_SOLOMON_PARITY_GF256_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define RSPAR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define RSPAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RSPAR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define RSPAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/rspar_pkg.sv]
package rspar_pkg;

   // Largest generator degree held in the coefficient and remainder registers
   localparam int MAX_PARITY   = 32;
   localparam int COUNT_WIDTH  = $clog2(MAX_PARITY + 1);
   localparam int CSR_WIDTH    = 6;
   localparam int RESET_PARITY = 10;

   // Field polynomial x^8+x^4+x^3+x^2+1 and the generator's primitive element
   localparam logic [8:0] GF_POLY  = 9'h11d;
   localparam logic [7:0] GF_ALPHA = 8'h02;

   typedef logic [MAX_PARITY-1:0][7:0] coeff_array_type;

   // GF(256) multiply, MSB-first shift and reduce
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] acc;
      acc = '0;
      for (int i = 7; i >= 0; i--) begin
         acc = {acc[7:0], 1'b0};
         if (acc[8]) begin
            acc = acc ^ GF_POLY;
         end
         if (b[i]) begin
            acc = acc ^ {1'b0, a};
         end
      end
      return acc[7:0];
   endfunction

   // Clamp a programmed count into 1..MAX_PARITY
   function automatic logic [COUNT_WIDTH-1:0] eff_count(input logic [CSR_WIDTH-1:0] value);
      logic [COUNT_WIDTH-1:0] n;
      if (value == '0) begin
         n = COUNT_WIDTH'(1);
      end else if (int'(value) > MAX_PARITY) begin
         n = COUNT_WIDTH'(MAX_PARITY);
      end else begin
         n = COUNT_WIDTH'(value);
      end
      return n;
   endfunction

   // Starting point of the generator build: the monic term alone
   function automatic coeff_array_type gen_seed(input logic [COUNT_WIDTH-1:0] n);
      coeff_array_type seed;
      seed = '0;
      for (int i = 0; i < MAX_PARITY; i++) begin
         if (i == int'(n) - 1) begin
            seed[i] = 8'h01;
         end
      end
      return seed;
   endfunction

endpackage

[hw/rtl/rspar_req_if.sv]
interface rspar_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_end;

   modport source (output valid, output data_byte, output block_end, input ready);
   modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

[hw/rtl/rspar_rsp_if.sv]
interface rspar_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_parity;
   logic       run_end;

   modport source (output valid, output out_byte, output is_parity, output run_end,
                   input ready);
   modport sink   (input valid, input out_byte, input is_parity, input run_end,
                   output ready);
endinterface

[hw/rtl/reed_solomon_parity_gf256_top.sv]
// Data beats: one beat per cycle while req_chan.ready is high, echo appears on rsp in the cycle after acceptance.
// A beat marked block_end is followed by n parity beats, one per cycle while the sink
// keeps rsp_chan.ready high, during which req_chan.ready is low.
// After reset or a csr write the generator is rebuilt (one root per cycle through
// 32 parallel GF multipliers) with req_chan.ready held low.
// Synchronous active-high reset: parity count 10, remainder cleared, rsp empty.
`include "reed_solomon_parity_gf256_top_defines.svh"

module reed_solomon_parity_gf256_top (
   input  logic                             clock,
   input  logic                             reset,
   rspar_req_if.sink                        req_chan,
   rspar_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [rspar_pkg::CSR_WIDTH-1:0]  csr_wr_data
);
   import rspar_pkg::*;

   // Control and arithmetic state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] build_left_ff, build_left_in;
   logic [COUNT_WIDTH-1:0] unload_left_ff, unload_left_in;
   logic                   unload_ff, unload_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             root_ff, root_in;
   coeff_array_type        gen_ff, gen_in;
   coeff_array_type        rem_ff, rem_in;

   // Result payload
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_parity_ff, out_parity_in;
   logic                   out_end_ff, out_end_in;

   logic                   load_ok;
   logic                   building;
   logic                   req_fire;
   logic                   out_load;
   logic [7:0]             factor;
   coeff_array_type        rem_shift;
   coeff_array_type        gen_shift;
   coeff_array_type        rem_step;
   coeff_array_type        gen_step;

   // Handshake
   assign building       = (build_left_ff != '0);
   assign load_ok        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !building && !unload_ff && load_ok;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.is_parity = out_parity_ff;
   assign rsp_chan.run_end   = out_end_ff;

   // Remainder division step and generator root step, one multiplier per tap
   always_comb begin
      factor    = req_chan.data_byte ^ rem_ff[0];
      rem_shift = coeff_array_type'(rem_ff >> 8);
      gen_shift = coeff_array_type'(gen_ff >> 8);
      for (int k = 0; k < MAX_PARITY; k++) begin
         rem_step[k] = gf_mul(gen_ff[k], factor) ^ rem_shift[k];
         gen_step[k] = gf_mul(gen_ff[k], root_ff) ^ gen_shift[k];
      end
   end

   // Next state
   always_comb begin
      count_in       = count_ff;
      build_left_in  = build_left_ff;
      unload_left_in = unload_left_ff;
      unload_in      = unload_ff;
      root_in        = root_ff;
      gen_in         = gen_ff;
      rem_in         = rem_ff;
      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_parity_in  = out_parity_ff;
      out_end_in     = out_end_ff;
      out_load       = 1'b0;

      // drop a beat the sink has taken
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         // new degree: clear the remainder and restart the generator build
         count_in      = eff_count(csr_wr_data);
         build_left_in = eff_count(csr_wr_data);
         gen_in        = gen_seed(eff_count(csr_wr_data));
         root_in       = 8'h01;
         rem_in        = '0;
         unload_in     = 1'b0;
      end else if (building) begin
         // multiply in one more root (x - alpha^i)
         gen_in        = gen_step;
         root_in       = gf_mul(root_ff, GF_ALPHA);
         build_left_in = build_left_ff - COUNT_WIDTH'(1);
      end else if (unload_ff && load_ok) begin
         // shift out the next parity byte, highest degree first
         out_load       = 1'b1;
         out_byte_in    = rem_ff[0];
         out_parity_in  = 1'b1;
         out_end_in     = (unload_left_ff == COUNT_WIDTH'(1));
         rem_in         = rem_shift;
         unload_left_in = unload_left_ff - COUNT_WIDTH'(1);
         if (unload_left_ff == COUNT_WIDTH'(1)) begin
            unload_in = 1'b0;
         end
      end else if (req_fire) begin
         // echo the data beat and fold it into the remainder
         out_load      = 1'b1;
         out_byte_in   = req_chan.data_byte;
         out_parity_in = 1'b0;
         out_end_in    = 1'b0;
         rem_in        = rem_step;
         if (req_chan.block_end) begin
            unload_in      = 1'b1;
            unload_left_in = count_ff;
         end
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= COUNT_WIDTH'(RESET_PARITY);
         build_left_ff  <= COUNT_WIDTH'(RESET_PARITY);
         gen_ff         <= gen_seed(COUNT_WIDTH'(RESET_PARITY));
         root_ff        <= 8'h01;
         rem_ff         <= '0;
         unload_ff      <= 1'b0;
         unload_left_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         build_left_ff  <= build_left_in;
         gen_ff         <= gen_in;
         root_ff        <= root_in;
         rem_ff         <= rem_in;
         unload_ff      <= unload_in;
         unload_left_ff <= unload_left_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload, held while the sink stalls
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_parity_ff <= out_parity_in;
      out_end_ff    <= out_end_in;
   end

   `RSPAR_ASSERT_NOW(a_no_accept_busy, clock, reset, req_fire, !building && !unload_ff, "data beat accepted during build or parity unload")
   `RSPAR_ASSERT_NEXT(a_block_end_unloads, clock, reset, req_fire && req_chan.block_end && !csr_wr_en, unload_ff && unload_left_ff == count_ff, "block end did not start parity unload")
   `RSPAR_ASSERT_NEXT(a_rem_clear_after_block, clock, reset, !csr_wr_en && unload_ff && load_ok && unload_left_ff == COUNT_WIDTH'(1), rem_ff == '0 && !unload_ff && out_end_ff, "remainder not clear after last parity beat")
   `RSPAR_ASSERT_NEXT(a_csr_starts_build, clock, reset, csr_wr_en, building && rem_ff == '0, "register write did not restart generator build")

endmodule

[tb/tb.sv]
module tb;
   import rspar_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 40;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 24;
   localparam int OPEN_PHASE      = 2;
   localparam int DIRECTED_ROWS   = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_parity;
      logic       run_end;
   } code_beat_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
      logic       typed;
   } stim_row_type;

   // Directed blocks at the reset parity count: byte, block end, typed expectation.
   // All-zero blocks echo zeros and leave zero parity, so those are typed in.
   localparam logic [9:0] DIRECTED [0:DIRECTED_ROWS-1] = '{
      {8'h00, 1'b1, 1'b1},
      {8'h00, 1'b0, 1'b1}, {8'h00, 1'b0, 1'b1}, {8'h00, 1'b1, 1'b1},
      {8'hff, 1'b1, 1'b0},
      {8'h01, 1'b1, 1'b0},
      {8'h80, 1'b0, 1'b0}, {8'h55, 1'b0, 1'b0}, {8'haa, 1'b0, 1'b0}, {8'hff, 1'b1, 1'b0},
      {8'h01, 1'b0, 1'b0}, {8'h02, 1'b0, 1'b0}, {8'h04, 1'b0, 1'b0}, {8'h08, 1'b0, 1'b0},
      {8'h10, 1'b0, 1'b0}, {8'h20, 1'b0, 1'b0}, {8'h40, 1'b0, 1'b0}, {8'h80, 1'b1, 1'b0},
      {8'h00, 1'b0, 1'b0}, {8'h7f, 1'b1, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_WIDTH-1:0] csr_wr_data;
   logic                 beat_typed;
   logic                 sender_idle;
   logic                 sink_idle;
   int                   sink_hold;
   int                   stuck_cycles;
   int                   fail_count;
   int                   data_beats;
   int                   parity_beats;
   int                   blocks_closed;
   int                   settings_used;

   // Encoder state mirrored in the bench
   logic [CSR_WIDTH-1:0] parity_setting;
   logic [7:0]           gen_coeffs [MAX_PARITY];
   logic [7:0]           rem_bytes  [MAX_PARITY];
   code_beat_type        due_beats  [$];

   rspar_req_if req_chan ();
   rspar_rsp_if rsp_chan ();

   reed_solomon_parity_gf256_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // GF(256) product, LSB first with the multiplicand doubled each step
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] mult;
      logic [7:0] sel;
      acc  = '0;
      mult = a;
      sel  = b;
      for (int i = 0; i < 8; i++) begin
         if (sel[0]) begin
            acc = acc ^ mult;
         end
         mult = mult[7] ? ({mult[6:0], 1'b0} ^ GF_POLY[7:0]) : {mult[6:0], 1'b0};
         sel  = sel >> 1;
      end
      return acc;
   endfunction

   // Clamp the programmed count into the range the encoder supports
   function automatic int parity_degree(input logic [CSR_WIDTH-1:0] setting);
      if (setting == '0) begin
         return 1;
      end
      if (int'(setting) > MAX_PARITY) begin
         return MAX_PARITY;
      end
      return int'(setting);
   endfunction

   // Take a new parity count: rebuild the generator and clear the remainder
   task automatic load_parity_setting(input logic [CSR_WIDTH-1:0] setting);
      int         n;
      logic [7:0] root;
      parity_setting = setting;
      n    = parity_degree(setting);
      root = 8'h01;
      for (int k = 0; k < MAX_PARITY; k++) begin
         gen_coeffs[k] = 8'h00;
         rem_bytes[k]  = 8'h00;
      end
      gen_coeffs[n-1] = 8'h01;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j + 1 < n; j++) begin
            gen_coeffs[j] = gf_times(gen_coeffs[j], root) ^ gen_coeffs[j+1];
         end
         gen_coeffs[n-1] = gf_times(gen_coeffs[n-1], root);
         root = gf_times(root, GF_ALPHA);
      end
   endtask

   // Divide one data byte into the remainder and queue its echo and any parity
   task automatic absorb_byte(input logic [7:0] data, input logic last, input logic typed);
      int         n;
      logic [7:0] factor;
      n      = parity_degree(parity_setting);
      factor = data ^ rem_bytes[0];
      for (int k = 0; k + 1 < n; k++) begin
         rem_bytes[k] = gf_times(gen_coeffs[k], factor) ^ rem_bytes[k+1];
      end
      rem_bytes[n-1] = gf_times(gen_coeffs[n-1], factor);
      due_beats.push_back('{data, 1'b0, 1'b0});
      if (last) begin
         if (typed) begin
            for (int k = 0; k < RESET_PARITY; k++) begin
               due_beats.push_back('{8'h00, 1'b1, k == RESET_PARITY - 1});
            end
         end else begin
            for (int k = 0; k < n; k++) begin
               due_beats.push_back('{rem_bytes[k], 1'b1, k == n - 1});
            end
         end
         for (int k = 0; k < MAX_PARITY; k++) begin
            rem_bytes[k] = 8'h00;
         end
      end
   endtask

   // Predict on accepted data beats, check accepted result beats
   always @(posedge clock) begin
      code_beat_type want;
      code_beat_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            absorb_byte(req_chan.data_byte, req_chan.block_end, beat_typed);
            data_beats++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.out_byte, rsp_chan.is_parity, rsp_chan.run_end};
            if (got.is_parity) begin
               parity_beats++;
            end
            if (got.run_end) begin
               blocks_closed++;
            end
            if (due_beats.size() == 0) begin
               $display("%0t: unexpected beat: byte %02h parity %0b end %0b",
                        $time, got.out_byte, got.is_parity, got.run_end);
               fail_count++;
            end else begin
               want = due_beats.pop_front();
               if (got !== want) begin
                  $display("%0t: beat mismatch: expected byte %02h parity %0b end %0b, %s",
                           $time, want.out_byte, want.is_parity, want.run_end, "actual");
                  $display("%0t:   actual byte %02h parity %0b end %0b",
                           $time, got.out_byte, got.is_parity, got.run_end);
                  fail_count++;
               end
            end
         end
      end
   end

   // Stall the result side in bursts of random length
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold      <= sink_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 11) == 0) begin
         sink_hold      <= $urandom_range(0, 15);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Abandon the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
      begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no beat moved for %0d cycles, %0d results outstanding",
                  $time, stuck_cycles, due_beats.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offer one data beat, after an optional gap, and hold it until accepted
   task automatic send_beat(input logic [7:0] data, input logic last, input logic typed);
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.block_end <= last;
      beat_typed         <= typed;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (due_beats.size() != 0) @(negedge clock);
   endtask

   // Program the parity count; only called with the encoder idle
   task automatic write_setting(input logic [CSR_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      load_parity_setting(value);
      settings_used++;
   endtask

   initial begin
      stim_row_type         row;
      logic [CSR_WIDTH-1:0] setting;
      logic [7:0]           data;
      int                   phase_items;
      int                   block_len;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.block_end = 1'b0;
      rsp_chan.ready     = 1'b0;
      beat_typed         = 1'b0;
      sender_idle        = 1'b1;
      sink_idle          = 1'b1;
      sink_hold          = 0;
      stuck_cycles       = 0;
      fail_count         = 0;
      data_beats         = 0;
      parity_beats       = 0;
      blocks_closed      = 0;
      settings_used      = 1;
      load_parity_setting(CSR_WIDTH'(RESET_PARITY));

      // Hold reset, then release it on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed blocks at the reset count
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         send_beat(row.data_byte, row.block_end, row.typed);
      end
      settle();

      // Random blocks over a spread of parity counts, quiet in the last phase
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       setting = 6'd0;
            1:       setting = 6'd63;
            2:       setting = 6'd1;
            3:       setting = 6'd32;
            4:       setting = 6'd33;
            5:       setting = CSR_WIDTH'($urandom_range(2, 31));
            6:       setting = CSR_WIDTH'($urandom_range(0, 63));
            default: setting = CSR_WIDTH'($urandom_range(1, 32));
         endcase
         write_setting(setting);
         sender_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         sink_idle   = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            block_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
            for (int i = 0; i < block_len; i++) begin
               case ($urandom_range(0, 15))
                  0:       data = 8'h00;
                  1:       data = 8'hff;
                  default: data = 8'($urandom_range(0, 255));
               endcase
               send_beat(data, i == block_len - 1, 1'b0);
            end
            phase_items += block_len;
            if (sender_idle && $urandom_range(0, 15) == 0) begin
               settle();
            end
         end
         // Leave a block open so the next count write restarts its parity
         if (p == OPEN_PHASE) begin
            for (int i = 0; i < 3; i++) begin
               send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d data beats, %0d parity beats, %0d closed blocks", data_beats,
               parity_beats, blocks_closed);
      $display("over %0d parity count settings, clamped counts and an abandoned block included",
               settings_used);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
